// ===== sv/i14a_pkg.sv =====
// ----------------------------------------------------------------------------
// i14a_pkg
// Shared types and constants for the ISO 14443-A select sniffer.
// ----------------------------------------------------------------------------
package i14a_pkg;

  // Default number of frame bytes kept and logged per frame.
  localparam int FRAME_BYTES_DEF = 32;
  // UID bytes carried in the select header.
  localparam int UID_BYTES = 10;
  // Bytes in the select header record.
  localparam int HDR_BYTES = 17;
  // Frame byte counter width and saturation value.
  localparam int COUNT_W = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

  // Record kinds.
  localparam logic [1:0] KIND_HDR  = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;

  // Protocol constants.
  localparam logic [15:0] CRC_INIT    = 16'h6363;
  localparam logic [15:0] CRC_POLY    = 16'h8408;
  localparam logic [7:0]  SEL_CL1     = 8'h93;
  localparam logic [7:0]  NVB_ANTICOL = 8'h20;
  localparam logic [7:0]  NVB_SELECT  = 8'h70;
  localparam logic [7:0]  CT_BYTE     = 8'h88;
  localparam logic [7:0]  MARK_BYTE   = 8'hFF;
  localparam logic [3:0]  SHORT_BITS  = 4'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       from_reader;
    logic       frame_end;
    logic [3:0] last_bits;
  } in_word_t;

  typedef struct packed {
    logic [7:0] trace_byte;
    logic [1:0] record_kind;
    logic       record_end;
    logic       run_end;
    logic       truncated;
  } out_word_t;

  // One logging job: a frame sitting in one buffer bank, optionally
  // preceded by the select header captured when the frame ended.
  typedef struct packed {
    logic                          bank;
    logic [COUNT_W-1:0]            count;
    logic                          trunc;
    logic [1:0]                    kind;
    logic                          hdr;
    logic [HDR_BYTES-1:0][7:0]     head;
  } job_t;

endpackage

// ===== sv/i14a_ram.sv =====
// ----------------------------------------------------------------------------
// i14a_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module i14a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/i14a_front.sv =====
// ----------------------------------------------------------------------------
// i14a_front
// Byte intake: buffers frame bytes, runs CRC_A and BCC, tracks the select
// sequence and queues a logging job for every frame logged after select.
// ----------------------------------------------------------------------------
module i14a_front import i14a_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int IDX_W = $clog2(FRAME_BYTES),
  localparam int ADDR_W = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              ram_wr_en,
  output logic [ADDR_W-1:0] ram_wr_addr,
  output logic [7:0]        ram_wr_data,
  output logic              job_push,
  output job_t              job,
  input  logic              job_done
);

  typedef enum logic [3:0] {
    PH_INIT, PH_WUPREQ, PH_ATQA, PH_ANTICOL, PH_SELECT,
    PH_SAK, PH_IDLE, PH_CMD, PH_RESP
  } phase_t;

  localparam int FIRST_BYTES = 4;

  phase_t                       phase;
  logic [1:0]                   cascade_level;
  logic [UID_BYTES-1:0][7:0]    uid_store;
  logic [1:0][7:0]              atqa_store;
  logic [7:0]                   sak_store;
  logic [COUNT_W-1:0]           byte_count;
  logic [15:0]                  running_crc;
  logic [7:0]                   running_xor;
  logic [FIRST_BYTES-1:0][7:0]  first_bytes;
  logic                         wr_bank;
  logic [1:0]                   pending;

  logic                         accept;
  logic [7:0]                   b;
  logic [15:0]                  crc_next;
  logic [7:0]                   xor_next;
  logic [COUNT_W-1:0]           n;
  logic [FIRST_BYTES-1:0][7:0]  d;
  logic [1:0]                   lvl;
  logic                         crc_ok;
  logic                         bcc_ok;
  logic                         short_frame;
  logic                         in_first;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] v);
    logic [15:0] c;
    c = crc ^ {8'h00, v};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Two logged frames may be outstanding: one being drained by the back
  // end and one waiting. A third would overwrite the bank being drained.
  assign in_ready = (pending < 2'd2);
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign crc_next = crc_byte(running_crc, b);
  assign xor_next = running_xor ^ b;
  assign n        = (byte_count < COUNT_MAX) ? byte_count + 1'b1 : byte_count;
  assign crc_ok   = (crc_next == 16'h0000);
  assign bcc_ok   = (xor_next == 8'h00);
  assign lvl      = (cascade_level > 2'd2) ? 2'd2 : cascade_level;
  assign in_first = (byte_count < COUNT_W'(FIRST_BYTES));
  assign short_frame = in_data.from_reader && (n == COUNT_W'(1))
                       && (in_data.last_bits == SHORT_BITS);

  always_comb begin
    d = first_bytes;
    if (in_first) begin
      d[byte_count[1:0]] = b;
    end
  end

  assign ram_wr_en   = accept && (byte_count < COUNT_W'(FRAME_BYTES));
  assign ram_wr_addr = {wr_bank, byte_count[IDX_W-1:0]};
  assign ram_wr_data = b;

  assign job_push = accept && in_data.frame_end && !short_frame
                    && (phase == PH_IDLE || phase == PH_CMD || phase == PH_RESP);

  always_comb begin
    job.bank  = wr_bank;
    job.trunc = (n > COUNT_W'(FRAME_BYTES));
    job.count = job.trunc ? COUNT_W'(FRAME_BYTES) : n;
    job.kind  = (phase == PH_RESP) ? KIND_RESP : KIND_CMD;
    job.hdr   = (phase == PH_IDLE);
    job.head[0] = MARK_BYTE;
    job.head[1] = MARK_BYTE;
    for (int i = 0; i < UID_BYTES; i++) begin
      job.head[2 + i] = uid_store[i];
    end
    job.head[UID_BYTES + 2] = atqa_store[0];
    job.head[UID_BYTES + 3] = atqa_store[1];
    job.head[UID_BYTES + 4] = sak_store;
    job.head[UID_BYTES + 5] = MARK_BYTE;
    job.head[UID_BYTES + 6] = MARK_BYTE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_INIT;
      cascade_level <= 2'd0;
      uid_store     <= '0;
      atqa_store    <= '0;
      sak_store     <= 8'h00;
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      running_xor   <= 8'h00;
      wr_bank       <= 1'b0;
      pending       <= 2'd0;
    end else begin
      if (job_push && !job_done) begin
        pending <= pending + 2'd1;
      end else if (!job_push && job_done) begin
        pending <= pending - 2'd1;
      end

      if (accept) begin
        if (in_first) begin
          first_bytes[byte_count[1:0]] <= b;
        end
        if (!in_data.frame_end) begin
          byte_count  <= n;
          running_crc <= crc_next;
          running_xor <= xor_next;
        end else begin
          byte_count  <= '0;
          running_crc <= CRC_INIT;
          running_xor <= 8'h00;
          if (short_frame) begin
            uid_store     <= '0;
            atqa_store    <= '0;
            sak_store     <= 8'h00;
            cascade_level <= 2'd0;
            phase         <= PH_WUPREQ;
          end else begin
            unique case (phase)
              PH_INIT: begin
              end
              PH_WUPREQ: begin
                if (!in_data.from_reader && n == COUNT_W'(2)) begin
                  atqa_store[0] <= d[0];
                  atqa_store[1] <= d[1];
                  phase         <= PH_ATQA;
                end
              end
              PH_ATQA: begin
                if (in_data.from_reader && n == COUNT_W'(2)
                    && d[0] == SEL_CL1 && d[1] == NVB_ANTICOL) begin
                  phase <= PH_ANTICOL;
                end
              end
              PH_ANTICOL: begin
                if (!in_data.from_reader && n == COUNT_W'(5) && bcc_ok) begin
                  if (lvl == 2'd0) begin
                    uid_store[3:0] <= d;
                  end else if (lvl == 2'd1) begin
                    uid_store[2:0] <= uid_store[3:1];
                    uid_store[6:3] <= d;
                  end else begin
                    uid_store[5:3] <= uid_store[6:4];
                    uid_store[9:6] <= d;
                  end
                  phase <= PH_SELECT;
                end
              end
              PH_SELECT: begin
                if (in_data.from_reader && n == COUNT_W'(9)
                    && d[0] == SEL_CL1 + {5'b00000, lvl, 1'b0}
                    && d[1] == NVB_SELECT && crc_ok) begin
                  phase <= PH_SAK;
                end
              end
              PH_SAK: begin
                if (!in_data.from_reader && n == COUNT_W'(3) && crc_ok) begin
                  sak_store <= d[0];
                  if (lvl == 2'd0 && uid_store[0] == CT_BYTE) begin
                    cascade_level <= 2'd1;
                    phase         <= PH_ANTICOL;
                  end else if (lvl == 2'd1 && uid_store[3] == CT_BYTE) begin
                    cascade_level <= 2'd2;
                    phase         <= PH_ANTICOL;
                  end else begin
                    phase <= PH_IDLE;
                  end
                end
              end
              PH_IDLE, PH_CMD: begin
                phase   <= PH_RESP;
                wr_bank <= ~wr_bank;
              end
              PH_RESP: begin
                phase   <= PH_CMD;
                wr_bank <= ~wr_bank;
              end
              default: begin
                phase <= PH_INIT;
              end
            endcase
          end
        end
      end
    end
  end

endmodule

// ===== sv/i14a_jobq.sv =====
// ----------------------------------------------------------------------------
// i14a_jobq
// Two-entry queue of logging jobs between the intake and the trace writer.
// ----------------------------------------------------------------------------
module i14a_jobq import i14a_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       slots [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;

  assign head_valid = (fill != 2'd0);
  assign head_job   = slots[rd_ptr];

  // The intake never has more than two jobs outstanding, so a push
  // always finds room.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_job;
        wr_ptr        <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (!push && pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== sv/i14a_back.sv =====
// ----------------------------------------------------------------------------
// i14a_back
// Trace writer: emits the select header and the buffered frame bytes of
// each job through a registered output word.
// ----------------------------------------------------------------------------
module i14a_back import i14a_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  localparam int IDX_W = $clog2(FRAME_BYTES),
  localparam int ADDR_W = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  job_t              job,
  output logic              job_pop,
  output logic              ram_rd_en,
  output logic [ADDR_W-1:0] ram_rd_addr,
  input  logic [7:0]        ram_rd_data,
  output logic              job_done,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data
);

  typedef enum logic [1:0] {B_IDLE, B_HDR, B_READ, B_WAIT} bstate_t;

  bstate_t            state;
  job_t               cur;
  logic [COUNT_W-1:0] idx;
  logic               slot_free;
  logic               last_byte;
  logic               last_head;

  assign slot_free   = !out_valid || out_ready;
  assign last_byte   = (idx == cur.count - 1'b1);
  assign last_head   = (idx == COUNT_W'(HDR_BYTES - 1));
  assign job_pop     = (state == B_IDLE) && job_valid;
  assign ram_rd_en   = (state == B_READ);
  assign ram_rd_addr = {cur.bank, idx[IDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      job_done  <= 1'b0;
      idx       <= '0;
    end else begin
      job_done <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (job_valid) begin
            cur   <= job;
            idx   <= '0;
            state <= job.hdr ? B_HDR : B_READ;
          end
        end
        B_HDR: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_data.trace_byte  <= cur.head[idx[4:0]];
            out_data.record_kind <= KIND_HDR;
            out_data.record_end  <= last_head;
            out_data.run_end     <= 1'b0;
            out_data.truncated   <= 1'b0;
            if (last_head) begin
              idx   <= '0;
              state <= B_READ;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        B_READ: begin
          state <= B_WAIT;
        end
        B_WAIT: begin
          if (slot_free) begin
            out_valid            <= 1'b1;
            out_data.trace_byte  <= ram_rd_data;
            out_data.record_kind <= cur.kind;
            out_data.record_end  <= last_byte;
            out_data.run_end     <= last_byte;
            out_data.truncated   <= cur.trunc;
            if (last_byte) begin
              job_done <= 1'b1;
              state    <= B_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= B_READ;
            end
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/iso14443a_select_sniffer.sv =====
// ----------------------------------------------------------------------------
// iso14443a_select_sniffer
// Follows the ISO 14443-A select sequence and writes a byte trace.
// ----------------------------------------------------------------------------
// The input channel carries one sniffed frame byte per word, with the frame
// direction, a mark on the final byte and the valid bit count of that byte.
// The output channel carries one trace byte per word. After a select has
// completed, the next frame produces a 17-byte header (FF FF, UID, ATQA,
// SAK, FF FF) followed by the frame itself, and later frames are logged as
// alternating command and response records. A one-byte 7-bit reader frame
// restarts the sequence at any time.
// An input word is taken whenever in_ready is high. A frame end that logs
// a frame hands a job to a two-entry queue; an idle trace writer takes it
// from the queue, then sends header bytes at one per cycle while out_ready
// holds, and each frame byte after a read of the frame buffer RAM and a
// wait for its registered read data.
// The frame buffer has two banks; in_ready drops only while two logged
// frames are outstanding, so a stalled receiver holds up the intake only
// after that. Reset (synchronous, active high) returns the sequence to its
// initial phase, clears the stores and empties the job queue.
// ----------------------------------------------------------------------------
module iso14443a_select_sniffer import i14a_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IDX_W  = $clog2(FRAME_BYTES);
  localparam int ADDR_W = IDX_W + 1;
  localparam int RAM_DEPTH = 2 ** ADDR_W;

  logic              ram_wr_en;
  logic [ADDR_W-1:0] ram_wr_addr;
  logic [7:0]        ram_wr_data;
  logic              ram_rd_en;
  logic [ADDR_W-1:0] ram_rd_addr;
  logic [7:0]        ram_rd_data;

  logic job_push;
  job_t push_job;
  logic job_pop;
  logic job_valid;
  job_t head_job;
  logic job_done;

  // Intake, sequence tracking and CRC/BCC checks.
  i14a_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .job_push    (job_push),
    .job         (push_job),
    .job_done    (job_done)
  );

  // Two banks of frame bytes, one being filled while the other drains.
  i14a_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  i14a_jobq u_jobq (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (push_job),
    .pop        (job_pop),
    .head_valid (job_valid),
    .head_job   (head_job)
  );

  // Trace writer with the registered output word.
  i14a_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_valid   (job_valid),
    .job         (head_job),
    .job_pop     (job_pop),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .job_done    (job_done),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// ===== sv/i14a_checker.sv =====
// ----------------------------------------------------------------------------
// i14a_checker
// Port-level checks on the trace output of the select sniffer.
// ----------------------------------------------------------------------------
module i14a_checker import i14a_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // A stalled trace word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("trace word changed while stalled");

  // The last word of a run always closes a record.
  a_run_closes_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.run_end |-> out_data.record_end)
    else $error("run end without record end");

  // A header is always followed by its frame and is never truncated.
  a_header_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.record_kind == KIND_HDR |->
      !out_data.run_end && !out_data.truncated)
    else $error("bad header word");

  // After a header closes, the next word starts a command record.
  a_header_then_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.record_kind == KIND_HDR
      && out_data.record_end |=> !out_valid || out_data.record_kind == KIND_CMD)
    else $error("header not followed by command record");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("trace word valid after reset");

endmodule

bind iso14443a_select_sniffer i14a_checker u_checker (.*);

// ===== tb/sv/select_trace_checker.sv =====
// ----------------------------------------------------------------------------
// select_trace_checker
// Predicts and checks the trace written by the ISO 14443-A select sniffer.
// ----------------------------------------------------------------------------
// Watches both channels of the sniffer. Every accepted input word advances a
// private copy of the select sequence, and the trace words it causes are
// queued. Every accepted output word is compared with the oldest queued word.
// ----------------------------------------------------------------------------
module select_trace_checker import i14a_pkg::*; #(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_word_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_word_t out_data,
  output int        mismatches,
  output int        due_words,
  output int        words_in,
  output int        words_out,
  output int        headers,
  output int        cut_records,
  output int        deep_selects
);

  typedef enum logic [3:0] {
    S_OFF, S_WAIT_ATQA, S_WAIT_ANTICOL, S_WAIT_UID, S_WAIT_SELECT,
    S_WAIT_SAK, S_SELECTED, S_LOG_CMD, S_LOG_RESP
  } sel_state_t;

  sel_state_t         sel_state;
  logic [1:0]         casc;
  logic [7:0]         uid_q [UID_BYTES];
  logic [7:0]         atqa_q [2];
  logic [7:0]         sak_q;
  logic [7:0]         frame_q [FRAME_BYTES];
  logic [COUNT_W-1:0] fill;
  logic [15:0]        crc_acc;
  logic [7:0]         bcc_acc;
  out_word_t          trace_due [$];

  int n_fail = 0;
  int n_in   = 0;
  int n_out  = 0;
  int n_hdr  = 0;
  int n_cut  = 0;
  int n_deep = 0;

  function automatic logic [15:0] crc_a_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void clear_ids();
    foreach (uid_q[i]) uid_q[i] = 8'h00;
    atqa_q[0] = 8'h00;
    atqa_q[1] = 8'h00;
    sak_q     = 8'h00;
    casc      = 2'd0;
  endfunction

  function automatic void note(input logic [7:0] b, input logic [1:0] kind,
                               input logic rec_end, input logic cut);
    out_word_t w;
    w.trace_byte  = b;
    w.record_kind = kind;
    w.record_end  = rec_end;
    w.run_end     = 1'b0;
    w.truncated   = cut;
    trace_due.push_back(w);
  endfunction

  function automatic void log_frame(input int unsigned n, input logic [1:0] kind);
    logic        cut;
    int unsigned m;
    cut = (n > FRAME_BYTES);
    m   = cut ? FRAME_BYTES : n;
    for (int unsigned i = 0; i < m; i++) note(frame_q[i], kind, (i + 1 == m), cut);
    if (cut) n_cut++;
  endfunction

  function automatic void absorb_word(input in_word_t w);
    int unsigned n;
    int unsigned lvl;
    int          mark;
    logic        crc_good;
    logic        bcc_good;
    out_word_t   last;
    mark = trace_due.size();
    if (fill < FRAME_BYTES) frame_q[fill] = w.data_byte;
    crc_acc = crc_a_step(crc_acc, w.data_byte);
    bcc_acc = bcc_acc ^ w.data_byte;
    if (fill != COUNT_MAX) fill = fill + 1'b1;
    if (w.frame_end) begin
      n        = fill;
      crc_good = (crc_acc == 16'h0000);
      bcc_good = (bcc_acc == 8'h00);
      fill     = '0;
      crc_acc  = CRC_INIT;
      bcc_acc  = 8'h00;
      lvl      = (casc > 2'd2) ? 2 : casc;
      if (w.from_reader && n == 1 && w.last_bits == SHORT_BITS) begin
        // A short reader frame restarts the sequence from any state.
        clear_ids();
        sel_state = S_WAIT_ATQA;
      end else begin
        case (sel_state)
          S_OFF: ;
          S_WAIT_ATQA: begin
            if (!w.from_reader && n == 2) begin
              atqa_q[0] = frame_q[0];
              atqa_q[1] = frame_q[1];
              sel_state = S_WAIT_ANTICOL;
            end
          end
          S_WAIT_ANTICOL: begin
            if (w.from_reader && n == 2 && frame_q[0] == SEL_CL1 &&
                frame_q[1] == NVB_ANTICOL)
              sel_state = S_WAIT_UID;
          end
          S_WAIT_UID: begin
            if (!w.from_reader && n == 5 && bcc_good) begin
              if (lvl == 0) begin
                for (int i = 0; i < 4; i++) uid_q[i] = frame_q[i];
              end else if (lvl == 1) begin
                for (int i = 0; i < 3; i++) uid_q[i] = uid_q[i + 1];
                for (int i = 0; i < 4; i++) uid_q[3 + i] = frame_q[i];
              end else begin
                for (int i = 0; i < 3; i++) uid_q[3 + i] = uid_q[4 + i];
                for (int i = 0; i < 4; i++) uid_q[6 + i] = frame_q[i];
              end
              sel_state = S_WAIT_SELECT;
            end
          end
          S_WAIT_SELECT: begin
            if (w.from_reader && n == 9 && frame_q[0] == SEL_CL1 + 8'(2 * lvl) &&
                frame_q[1] == NVB_SELECT && crc_good)
              sel_state = S_WAIT_SAK;
          end
          S_WAIT_SAK: begin
            if (!w.from_reader && n == 3 && crc_good) begin
              sak_q = frame_q[0];
              if (lvl == 0 && uid_q[0] == CT_BYTE) begin
                casc      = 2'd1;
                sel_state = S_WAIT_UID;
              end else if (lvl == 1 && uid_q[3] == CT_BYTE) begin
                casc      = 2'd2;
                sel_state = S_WAIT_UID;
              end else begin
                if (lvl == 2) n_deep++;
                sel_state = S_SELECTED;
              end
            end
          end
          S_SELECTED: begin
            note(MARK_BYTE, KIND_HDR, 1'b0, 1'b0);
            note(MARK_BYTE, KIND_HDR, 1'b0, 1'b0);
            for (int i = 0; i < UID_BYTES; i++) note(uid_q[i], KIND_HDR, 1'b0, 1'b0);
            note(atqa_q[0], KIND_HDR, 1'b0, 1'b0);
            note(atqa_q[1], KIND_HDR, 1'b0, 1'b0);
            note(sak_q, KIND_HDR, 1'b0, 1'b0);
            note(MARK_BYTE, KIND_HDR, 1'b0, 1'b0);
            note(MARK_BYTE, KIND_HDR, 1'b1, 1'b0);
            n_hdr++;
            log_frame(n, KIND_CMD);
            sel_state = S_LOG_RESP;
          end
          S_LOG_CMD: begin
            log_frame(n, KIND_CMD);
            sel_state = S_LOG_RESP;
          end
          S_LOG_RESP: begin
            log_frame(n, KIND_RESP);
            sel_state = S_LOG_CMD;
          end
          default: sel_state = S_OFF;
        endcase
      end
      if (trace_due.size() > mark) begin
        last = trace_due.pop_back();
        last.run_end = 1'b1;
        trace_due.push_back(last);
      end
    end
  endfunction

  function automatic void check_word(input out_word_t got);
    out_word_t want;
    if (trace_due.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("trace word %0d arrived with nothing expected: byte %h kind %0d",
                 n_out, got.trace_byte, got.record_kind);
    end else begin
      want = trace_due.pop_front();
      if (got.trace_byte !== want.trace_byte || got.record_kind !== want.record_kind ||
          got.record_end !== want.record_end || got.run_end !== want.run_end ||
          got.truncated !== want.truncated) begin
        n_fail++;
        if (n_fail <= 10)
          $display("trace word %0d: expected %h/%0d/%b/%b/%b, got %h/%0d/%b/%b/%b %s",
                   n_out, want.trace_byte, want.record_kind, want.record_end,
                   want.run_end, want.truncated, got.trace_byte, got.record_kind,
                   got.record_end, got.run_end, got.truncated,
                   "(byte/kind/record end/run end/truncated)");
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sel_state = S_OFF;
      clear_ids();
      foreach (frame_q[i]) frame_q[i] = 8'h00;
      fill    = '0;
      crc_acc = CRC_INIT;
      bcc_acc = 8'h00;
      trace_due.delete();
    end else begin
      if (in_valid && in_ready) begin
        n_in++;
        absorb_word(in_data);
      end
      if (out_valid && out_ready) begin
        n_out++;
        check_word(out_data);
      end
    end
    mismatches   <= n_fail;
    due_words    <= trace_due.size();
    words_in     <= n_in;
    words_out    <= n_out;
    headers      <= n_hdr;
    cut_records  <= n_cut;
    deep_selects <= n_deep;
  end

endmodule

// ===== tb/sv/tb_iso14443a_select_sniffer.sv =====
// ----------------------------------------------------------------------------
// tb_iso14443a_select_sniffer
// Stimulus and verdict for the ISO 14443-A select sniffer.
// ----------------------------------------------------------------------------
// Sniffed air traffic is fed in one byte per word: a short directed run
// through one complete select and two logged frames, then random select
// sessions of one to three cascade levels with random UIDs, each completed
// one followed by random logged traffic. Some protocol frames are preceded by
// a spoiled copy that the sequence must ignore, and short noise bursts sit
// between sessions. The checker beside the block predicts and compares every
// trace word; this module only drives the channels and reports the outcome.
// ----------------------------------------------------------------------------
module tb_iso14443a_select_sniffer;
  import i14a_pkg::*;

  // Air-interface commands that open a select sequence (both 7-bit frames).
  localparam logic [7:0] CMD_REQA  = 8'h26;
  localparam logic [7:0] CMD_WUPA  = 8'h52;
  localparam logic [3:0] FULL_BITS = 4'd8;

  // Amount of random traffic, the window in which neither side idles, and
  // the point and length of the long receiver hold-off.
  localparam int ITEMS       = 450;
  localparam int CALM_FROM   = 120;
  localparam int CALM_TO     = 220;
  localparam int HOLD_AT     = 250;
  localparam int HOLD_CYCLES = 500;

  // Ways of spoiling a protocol frame so the sequence has to skip it.
  typedef enum int {SPOIL_FLIP, SPOIL_TURN, SPOIL_CLIP, SPOIL_PAD} spoil_t;

  typedef logic [7:0] bytes_t [$];

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  logic      hold_rx    = 1'b0;
  int        words_sent = 0;
  logic      calm;

  int mismatches;
  int due_words;
  int words_in;
  int words_out;
  int headers;
  int cut_records;
  int deep_selects;

  // Both sides run without gaps inside this window of the input stream.
  assign calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  iso14443a_select_sniffer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  select_trace_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .due_words    (due_words),
    .words_in     (words_in),
    .words_out    (words_out),
    .headers      (headers),
    .cut_records  (cut_records),
    .deep_selects (deep_selects)
  );

  // Receiver: ready about four times in five, always ready in the calm
  // window, and held off completely while the hold-off process says so.
  always @(posedge clk) begin
    if (hold_rx) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 20);
    end
  end

  // Long receiver hold-off, counted here in cycles. The sender keeps
  // offering words meanwhile, so both frame banks fill and in_ready drops.
  initial begin : receiver_holdoff
    int held;
    wait (words_sent >= HOLD_AT);
    @(posedge clk);
    hold_rx <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Generous time ceiling, far beyond the slowest run.
  initial begin : watchdog
    #4000000;
    $display("Timeout: the run did not finish in time.");
    $display("FAIL iso14443a_select_sniffer");
    $finish;
  end

  // CRC_A over a whole frame, used to build valid SELECT and SAK frames.
  function automatic logic [15:0] crc_a_of(input bytes_t f);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (f[i]) begin
      c = c ^ {8'h00, f[i]};
      for (int j = 0; j < 8; j++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Offer one word and return at the edge that accepts it. Called right
  // after a rising edge. in_ready is looked at on the falling edge, where it
  // is settled, and the word is taken at the following rising edge.
  task automatic send_word(input in_word_t w);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    words_sent <= words_sent + 1;
  endtask

  // One frame, byte by byte. last_bits only means something on the final
  // byte, so the other bytes carry random values in its range.
  task automatic send_frame(input bytes_t f, input logic reader, input logic [3:0] bits);
    in_word_t w;
    for (int i = 0; i < f.size(); i++) begin
      w.data_byte   = f[i];
      w.from_reader = reader;
      w.frame_end   = (i == f.size() - 1);
      w.last_bits   = w.frame_end ? bits : 4'($urandom_range(1, 8));
      send_word(w);
    end
  endtask

  // A protocol frame, now and then preceded by a spoiled copy: a changed
  // byte, the wrong direction, a byte short, or padded past the buffer.
  // None of these may move the sequence on (a spoiled ATQA is the exception:
  // any two-byte tag frame counts as ATQA, and the true one is then skipped).
  task automatic send_step(input bytes_t f, input logic reader, input logic spoil_ok);
    bytes_t      bad;
    spoil_t      how;
    int unsigned at;
    int unsigned target;
    logic        turn;
    if (spoil_ok && $urandom_range(99) < 12) begin
      bad  = f;
      turn = 1'b0;
      how  = spoil_t'($urandom_range(3));
      case (how)
        SPOIL_FLIP: begin
          at      = $urandom_range(bad.size() - 1);
          bad[at] = bad[at] ^ 8'($urandom_range(1, 255));
        end
        SPOIL_TURN: turn = 1'b1;
        SPOIL_CLIP: bad.delete(bad.size() - 1);
        default: begin
          target = $urandom_range(FRAME_BYTES_DEF + 1, FRAME_BYTES_DEF + 8);
          while (bad.size() < target) bad.push_back(8'($urandom_range(255)));
        end
      endcase
      send_frame(bad, reader ^ turn, FULL_BITS);
    end
    send_frame(f, reader, FULL_BITS);
  endtask

  // One cascade level: anticollision command, UID part with BCC, SELECT
  // with CRC_A, and SAK with CRC_A.
  task automatic select_level(input int lvl, input bytes_t part, input logic [7:0] sak,
                              input logic spoil_ok);
    bytes_t      f;
    logic [7:0]  bcc;
    logic [15:0] c;
    bcc = 8'h00;
    f.push_back(SEL_CL1 + 8'(2 * lvl));
    f.push_back(NVB_ANTICOL);
    send_step(f, 1'b1, spoil_ok);
    f.delete();
    for (int i = 0; i < 4; i++) begin
      f.push_back(part[i]);
      bcc = bcc ^ part[i];
    end
    f.push_back(bcc);
    send_step(f, 1'b0, spoil_ok);
    f.push_front(NVB_SELECT);
    f.push_front(SEL_CL1 + 8'(2 * lvl));
    c = crc_a_of(f);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    send_step(f, 1'b1, spoil_ok);
    f.delete();
    f.push_back(sak);
    c = crc_a_of(f);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    send_step(f, 1'b0, spoil_ok);
  endtask

  // Random frame of either direction. Traffic frames are mostly short, a
  // few fill the buffer and a few run past it (some far enough to saturate
  // the byte counter); a traffic frame never happens to be a restart.
  task automatic send_random_frame(input logic traffic);
    bytes_t      f;
    int unsigned len;
    int unsigned r;
    logic        reader;
    logic [3:0]  bits;
    r = $urandom_range(99);
    if (!traffic || r < 80) begin
      len = $urandom_range(1, 12);
    end else if (r < 94) begin
      len = $urandom_range(13, FRAME_BYTES_DEF);
    end else begin
      len = $urandom_range(FRAME_BYTES_DEF + 1, 70);
    end
    reader = 1'($urandom_range(1));
    bits   = 4'($urandom_range(1, 8));
    if (traffic && reader && len == 1 && bits == SHORT_BITS) bits = FULL_BITS;
    repeat (len) f.push_back(8'($urandom_range(255)));
    send_frame(f, reader, bits);
  endtask

  // A select session: REQA or WUPA, ATQA, one to three cascade levels and
  // then logged traffic. Now and then it is abandoned part way, so that the
  // next session's REQA or WUPA has to restart a half-finished select.
  task automatic run_session(input int levels, input int logged);
    bytes_t f;
    bytes_t part;
    int     stop_at;
    stop_at = ($urandom_range(9) == 0) ? $urandom_range(levels - 1) : levels;
    f.push_back($urandom_range(1) ? CMD_REQA : CMD_WUPA);
    send_frame(f, 1'b1, SHORT_BITS);
    f.delete();
    f.push_back(8'($urandom_range(255)));
    f.push_back(8'($urandom_range(255)));
    send_step(f, 1'b0, 1'b1);
    for (int lvl = 0; lvl < stop_at; lvl++) begin
      part.delete();
      repeat (4) part.push_back(8'($urandom_range(255)));
      // The cascade tag leads to the next level; on the last level it must
      // be absent, except on level three, which completes regardless.
      if (lvl < levels - 1) begin
        part[0] = CT_BYTE;
      end else if (lvl < 2 && part[0] == CT_BYTE) begin
        part[0] = ~CT_BYTE;
      end else if (lvl == 2 && $urandom_range(3) == 0) begin
        part[0] = CT_BYTE;
      end
      select_level(lvl, part, 8'($urandom_range(255)), 1'b1);
    end
    if (stop_at == levels) begin
      repeat (logged) send_random_frame(1'b1);
    end
  endtask

  initial begin : stimulus
    bytes_t f;
    bytes_t part;
    int     spins;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A tag frame before any REQA is ignored; then a plain
    // single-level select with extreme UID bytes, and two one-byte frames:
    // the first brings the select header, the second a response record.
    f.push_back(8'h00);
    f.push_back(8'hFF);
    send_frame(f, 1'b0, FULL_BITS);
    f.delete();
    f.push_back(CMD_REQA);
    send_frame(f, 1'b1, SHORT_BITS);
    f.delete();
    f.push_back(8'h44);
    f.push_back(8'h00);
    send_frame(f, 1'b0, FULL_BITS);
    part.push_back(8'hFF);
    part.push_back(8'h00);
    part.push_back(8'h5A);
    part.push_back(8'hA5);
    select_level(0, part, 8'h20, 1'b0);
    f.delete();
    f.push_back(8'hFF);
    send_frame(f, 1'b1, FULL_BITS);
    f.delete();
    f.push_back(8'h00);
    send_frame(f, 1'b0, 4'd1);

    // Random part: mostly well-formed sessions, with noise bursts between.
    while (words_sent < ITEMS) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 3)) send_random_frame(1'b0);
      end else begin
        run_session($urandom_range(1, 3), $urandom_range(2, 8));
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every expected trace word, then give the block time
    // to show any word that should not be there. The count of due words is
    // registered behind the channels, so it is only read after an edge.
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (due_words != 0 && spins < 200000);
    repeat (150) @(posedge clk);

    $display("Covered %0d sniffed bytes and %0d trace words, with %0d select headers,",
             words_in, words_out, headers);
    $display("%0d truncated frame records and %0d selects through cascade level three.",
             cut_records, deep_selects);
    if (mismatches == 0 && due_words == 0) begin
      $display("PASS iso14443a_select_sniffer");
    end else begin
      if (due_words != 0) $display("%0d expected trace words never arrived.", due_words);
      $display("%0d trace words were wrong or unexpected.", mismatches);
      $display("FAIL iso14443a_select_sniffer");
    end
    $finish;
  end

endmodule
